/* rtl/core/iso_date_string_validator_assert.svh */
// Assertion macros for the date validator.
// Each use is one labeled concurrent assertion on the block clock, muted in reset.
`ifndef ISO_DATE_STRING_VALIDATOR_ASSERT_SVH
`define ISO_DATE_STRING_VALIDATOR_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define IDV_ASSERT_NOW(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Trigger in one cycle implies the outcome in the next.
`define IDV_ASSERT_NEXT(name, clk, rst, trig, outcome, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (outcome)) \
    else $error(msg);

`endif

/* rtl/core/idv_pkg.sv */
`default_nettype none

package idv_pkg;

  // Input beat: one character of the date string
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  // Result beat
  typedef struct packed {
    logic        valid_res;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
  } result_t;

  // Parsed record of one finished string, waiting for the range check
  typedef struct packed {
    logic        fmt_ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
  } fin_t;

  localparam logic [3:0]  POS_SAT   = 4'd11;
  localparam logic [3:0]  DATE_LEN  = 4'd10;
  localparam logic [3:0]  POS_DASH1 = 4'd4;
  localparam logic [3:0]  POS_DASH2 = 4'd7;
  localparam logic [7:0]  CH_DASH   = 8'h2D;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [13:0] YEAR_MIN  = 14'd2000;
  localparam logic [13:0] YEAR_MAX  = 14'd2100;
  // The one century year in range that is not a leap year
  localparam logic [13:0] YEAR_CENT = 14'd2100;
  localparam logic [6:0]  MONTH_MAX = 7'd12;

  // Field stop flags
  localparam int FLD_YEAR  = 0;
  localparam int FLD_MONTH = 1;
  localparam int FLD_DAY   = 2;

  // Days in a month 1..12; zero for anything else
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
      4'd2:                                      d = leap ? 5'd29 : 5'd28;
      default:                                   d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/idv_parse.sv */
`default_nettype none

module idv_parse (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire idv_pkg::item_t item,
  input  wire logic          fin_take,
  output logic               fin_valid,
  output idv_pkg::fin_t      fin
);

  logic [3:0]  pos;
  logic [13:0] year_acc;
  logic [6:0]  month_acc;
  logic [6:0]  day_acc;
  logic [2:0]  stopped;
  logic        dash_err;

  logic [3:0]  pos_next;
  logic [13:0] year_acc_next;
  logic [6:0]  month_acc_next;
  logic [6:0]  day_acc_next;
  logic [2:0]  stopped_next;
  logic        dash_err_next;
  logic        is_digit;
  logic [3:0]  dval;
  logic        fmt_ok;

  // Fold one character into the field its position selects
  always_comb begin
    year_acc_next  = year_acc;
    month_acc_next = month_acc;
    day_acc_next   = day_acc;
    stopped_next   = stopped;
    dash_err_next  = dash_err;
    is_digit       = (item.ch >= idv_pkg::CH_ZERO) && (item.ch <= idv_pkg::CH_NINE);
    dval           = 4'(item.ch - idv_pkg::CH_ZERO);

    case (pos) inside
      [4'd0:4'd3]: begin
        if (!stopped[idv_pkg::FLD_YEAR]) begin
          if (is_digit) year_acc_next = 14'(year_acc * 14'd10 + 14'(dval));
          else stopped_next[idv_pkg::FLD_YEAR] = 1'b1;
        end
      end
      idv_pkg::POS_DASH1, idv_pkg::POS_DASH2: begin
        if (item.ch != idv_pkg::CH_DASH) dash_err_next = 1'b1;
      end
      [4'd5:4'd6]: begin
        if (!stopped[idv_pkg::FLD_MONTH]) begin
          if (is_digit) month_acc_next = 7'(month_acc * 7'd10 + 7'(dval));
          else stopped_next[idv_pkg::FLD_MONTH] = 1'b1;
        end
      end
      [4'd8:4'd9]: begin
        if (!stopped[idv_pkg::FLD_DAY]) begin
          if (is_digit) day_acc_next = 7'(day_acc * 7'd10 + 7'(dval));
          else stopped_next[idv_pkg::FLD_DAY] = 1'b1;
        end
      end
      default: begin
      end
    endcase

    pos_next = (pos < idv_pkg::POS_SAT) ? 4'(pos + 4'd1) : pos;
    fmt_ok   = (pos_next == idv_pkg::DATE_LEN) && !dash_err_next;
  end

  // Advance the string state; clear it after the final character
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      year_acc  <= '0;
      month_acc <= '0;
      day_acc   <= '0;
      stopped   <= '0;
      dash_err  <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      // A new record wins over the drain of the old one
      if (accept && item.last) fin_valid <= 1'b1;
      else if (fin_take) fin_valid <= 1'b0;
      if (accept) begin
        if (item.last) begin
          pos       <= '0;
          year_acc  <= '0;
          month_acc <= '0;
          day_acc   <= '0;
          stopped   <= '0;
          dash_err  <= 1'b0;
        end else begin
          pos       <= pos_next;
          year_acc  <= year_acc_next;
          month_acc <= month_acc_next;
          day_acc   <= day_acc_next;
          stopped   <= stopped_next;
          dash_err  <= dash_err_next;
        end
      end
    end
  end

  // Capture the parsed record; a bad length or dash zeroes the fields
  always_ff @(posedge clk) begin
    if (accept && item.last) begin
      fin.fmt_ok <= fmt_ok;
      fin.year   <= fmt_ok ? year_acc_next  : '0;
      fin.month  <= fmt_ok ? month_acc_next : '0;
      fin.day    <= fmt_ok ? day_acc_next   : '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/idv_check.sv */
`default_nettype none

module idv_check (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fin_valid,
  input  wire idv_pkg::fin_t  fin,
  output logic                fin_take,
  output logic                result_valid,
  input  wire logic           result_stall,
  output idv_pkg::result_t    result
);

  logic       leap;
  logic [4:0] dim;
  logic       year_ok;
  logic       month_ok;
  logic       day_ok;
  logic       date_ok;

  // Range and day-of-month check; leap rule only needs to hold for 2000..2100
  always_comb begin
    year_ok  = (fin.year >= idv_pkg::YEAR_MIN) && (fin.year <= idv_pkg::YEAR_MAX);
    month_ok = (fin.month != 7'd0) && (fin.month <= idv_pkg::MONTH_MAX);
    leap     = (fin.year[1:0] == 2'b00) && (fin.year != idv_pkg::YEAR_CENT);
    dim      = idv_pkg::days_in_month(fin.month[3:0], leap);
    day_ok   = (fin.day != 7'd0) && (fin.day <= {2'b00, dim});
    date_ok  = fin.fmt_ok && year_ok && month_ok && day_ok;
  end

  // Output register moves when empty or when its beat is taken
  assign fin_take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_take) begin
      result_valid <= fin_valid;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (fin_take && fin_valid) begin
      result.valid_res <= date_ok;
      result.year      <= fin.year;
      result.month     <= fin.month;
      result.day       <= fin.day;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/iso_date_string_validator.sv */
// Streaming YYYY-MM-DD validator. Characters arrive one per beat, the final one
// flagged by last; the block takes one character every cycle while item_stall is
// low, with no gaps between strings. Each string gives one result beat: once its
// final character is taken, the parse stage's record slot holds the finished
// record, then the range check feeds the output register. item_stall rises only
// when both the record slot and the output register are full and the output is
// stalled. A result is valid when the string is exactly 10 characters, has dashes
// at offsets 4 and 7, and holds a year 2000..2100, a month 1..12 and a day within
// that month (Gregorian leap years). Wrong length or a missing dash reports zero
// year, month and day; a non-digit inside a field ends that field's value.
`default_nettype none

module iso_date_string_validator (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire idv_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output idv_pkg::result_t      result
);

  logic          accept;
  logic          fin_valid;
  logic          fin_take;
  idv_pkg::fin_t fin;

  // Stall only when the record slot is full and cannot drain
  assign item_stall = fin_valid && !fin_take;
  assign accept     = item_valid && !item_stall;

  idv_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .fin_take (fin_take),
    .fin_valid(fin_valid),
    .fin      (fin)
  );

  idv_check u_check (
    .clk         (clk),
    .rst         (rst),
    .fin_valid   (fin_valid),
    .fin         (fin),
    .fin_take    (fin_take),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

`include "iso_date_string_validator_assert.svh"

  // A final character always leaves a record behind
  `IDV_ASSERT_NEXT(a_last_makes_record, clk, rst, accept && item.last, fin_valid, "record lost")
  // A record that cannot drain holds
  `IDV_ASSERT_NEXT(a_record_holds, clk, rst, fin_valid && !fin_take, fin_valid && $stable(fin), "record dropped")
  // A valid date reports in-range fields
  `IDV_ASSERT_NOW(a_valid_ranges, clk, rst, !(result_valid && result.valid_res) || (result.year >= idv_pkg::YEAR_MIN && result.year <= idv_pkg::YEAR_MAX && result.month != 7'd0 && result.month <= idv_pkg::MONTH_MAX && result.day != 7'd0 && result.day <= 7'd31), "valid date out of range")

endmodule

`default_nettype wire
